### rtl/nfod_pkg.sv
`default_nettype none
package nfod_pkg;

  typedef logic [7:0]         byte_t;
  typedef logic signed [39:0] value_t;
  typedef logic [3:0]         index_t;
  typedef logic [1:0]         fmt_t;

  localparam byte_t NEWLINE = 8'h0A;

  // register indexes
  localparam logic REG_ELEMENT_COUNT_MODE = 1'b0;
  localparam logic REG_NUMBER_FORMAT      = 1'b1;

  // number formats
  localparam fmt_t FMT_FLOAT = 2'd0;
  localparam fmt_t FMT_Q15   = 2'd1;
  localparam fmt_t FMT_Q29   = 2'd2;
  localparam fmt_t FMT_Q31   = 2'd3;

  localparam index_t ANGLE_ELEMENTS = 4'd3;

  localparam value_t SAT_POS = 40'sh7F_FFFF_FFFF;
  localparam value_t SAT_NEG = 40'sh80_0000_0000;

  // float exponent for which the Q8.31 value is the mantissa unshifted
  localparam logic [7:0] EXP_UNITY = 8'd119;
  localparam logic [7:0] EXP_SAT   = 8'd135;

endpackage
`default_nettype wire

### rtl/nfod_if.sv
`default_nettype none
interface nfod_byte_if;
  import nfod_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nfod_result_if;
  import nfod_pkg::*;

  logic   valid;
  logic   ready;
  value_t element_value;
  index_t element_index;
  logic   last_of_packet;
  logic   frame_error;

  modport source (output valid, output element_value, output element_index,
                  output last_of_packet, output frame_error, input ready);
  modport sink   (input valid, input element_value, input element_index,
                  input last_of_packet, input frame_error, output ready);
endinterface
`default_nettype wire

### rtl/newline_framed_orientation_deframer_core.sv
`default_nettype none
// Deframer for newline-terminated orientation packets. Bytes arrive on rx;
// the block drops bytes until a newline, then stores a packet of 3 or
// MAX_ELEMENTS little-endian elements (2 bytes for Q15, 4 otherwise) in a
// small byte memory and checks the byte after it. A newline there releases
// one Q8.31 result per element on result; anything else releases a single
// error result and the block resynchronizes. The terminator starts a
// sequencer that reads the memory one byte at a time through states S_RD
// and S_CAP and runs each element through one shared format converter
// in S_CONV; rx.ready stays low until the sequencer (or the error
// result) is done, including any stall on result. The user must change
// configuration only while the block is idle; the block does not enforce it.
module newline_framed_orientation_deframer_core #(
  parameter int MAX_ELEMENTS = 9
) (
  input  wire logic      clk,
  input  wire logic      rst,
  nfod_byte_if.sink      rx,
  nfod_result_if.source  result,
  input  wire logic      cfg_we,
  input  wire logic      cfg_index,
  input  wire nfod_pkg::fmt_t cfg_data
);
  import nfod_pkg::*;

  localparam int DEPTH  = MAX_ELEMENTS * 4;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CAP  = 3'd2;
  localparam logic [2:0] S_CONV = 3'd3;
  localparam logic [2:0] S_ERR  = 3'd4;

  logic [2:0]       state;
  logic             in_sync;
  logic [POS_W-1:0] pos;
  logic             mode;
  fmt_t             fmt;

  logic [ADDR_W-1:0] rd_addr;
  byte_t             rd_data;
  logic [31:0]       word;
  logic [1:0]        kbyte;
  index_t            idx;
  index_t            elems_r;

  byte_t mem [DEPTH];

  index_t           elems;
  logic [POS_W-1:0] psize;
  logic             rx_fire;
  logic             out_free;
  logic             is_data;

  assign elems    = mode ? 4'(MAX_ELEMENTS) : ANGLE_ELEMENTS;
  assign psize    = (fmt == FMT_Q15) ? (POS_W'(elems) << 1) : (POS_W'(elems) << 2);
  assign rx.ready = (state == S_IDLE);
  assign rx_fire  = rx.valid && rx.ready;
  assign out_free = !result.valid || result.ready;
  assign is_data  = in_sync && (pos < psize);

  // ---- format converter, shared by all elements ----
  logic        f_neg;
  logic [7:0]  f_exp;
  logic [23:0] f_man;
  logic [7:0]  f_lsh;
  logic [7:0]  f_rsh;
  logic [38:0] f_mag;
  value_t      f_sat;
  value_t      conv;

  assign f_neg = word[31];
  assign f_exp = word[30:23];
  assign f_man = {1'b1, word[22:0]};
  assign f_lsh = f_exp - EXP_UNITY;
  assign f_rsh = EXP_UNITY - f_exp;
  assign f_sat = f_neg ? SAT_NEG : SAT_POS;

  always_comb begin
    f_mag = '0;
    if (f_exp >= EXP_UNITY) begin
      f_mag = 39'(f_man) << f_lsh[3:0];
    end else if (f_rsh < 8'd24) begin
      f_mag = 39'(f_man >> f_rsh[4:0]);
    end
    unique case (fmt)
      FMT_Q15: conv = {{8{word[15]}}, word[15:0], 16'h0000};
      FMT_Q29: conv = {{6{word[31]}}, word, 2'b00};
      FMT_Q31: conv = {{8{word[31]}}, word};
      default: begin
        priority if (f_exp == 8'hFF) begin
          conv = (word[22:0] != 23'd0) ? '0 : f_sat;
        end else if (f_exp == 8'h00) begin
          conv = '0;
        end else if (f_exp >= EXP_SAT) begin
          conv = f_sat;
        end else begin
          conv = f_neg ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
        end
      end
    endcase
  end

  // ---- packet memory ----
  always_ff @(posedge clk) begin
    if (rx_fire && is_data) begin
      mem[pos[ADDR_W-1:0]] <= rx.rx_byte;
    end
    rd_data <= mem[rd_addr];
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
      fmt  <= FMT_FLOAT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ELEMENT_COUNT_MODE: mode <= cfg_data[0];
        REG_NUMBER_FORMAT:      fmt  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- framing and sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_sync      <= 1'b0;
      pos          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rx_fire) begin
            if (!in_sync) begin
              if (rx.rx_byte == NEWLINE) begin
                in_sync <= 1'b1;
                pos     <= '0;
              end
            end else if (pos < psize) begin
              pos <= pos + 1'b1;
            end else begin
              pos     <= '0;
              rd_addr <= '0;
              kbyte   <= '0;
              idx     <= '0;
              elems_r <= elems;
              if (rx.rx_byte == NEWLINE) begin
                state <= S_RD;
              end else begin
                in_sync <= 1'b0;
                state   <= S_ERR;
              end
            end
          end
        end
        S_RD: begin
          state <= S_CAP;
        end
        S_CAP: begin
          word[{kbyte, 3'b000} +: 8] <= rd_data;
          rd_addr <= rd_addr + 1'b1;
          kbyte   <= kbyte + 1'b1;
          if (kbyte == ((fmt == FMT_Q15) ? 2'd1 : 2'd3)) begin
            state <= S_CONV;
          end else begin
            state <= S_RD;
          end
        end
        S_CONV: begin
          if (out_free) begin
            result.valid          <= 1'b1;
            result.element_value  <= conv;
            result.element_index  <= idx;
            result.last_of_packet <= (idx == elems_r - 1'b1);
            result.frame_error    <= 1'b0;
            kbyte                 <= '0;
            idx                   <= idx + 1'b1;
            state                 <= (idx == elems_r - 1'b1) ? S_IDLE : S_RD;
          end
        end
        S_ERR: begin
          if (out_free) begin
            result.valid          <= 1'b1;
            result.element_value  <= '0;
            result.element_index  <= '0;
            result.last_of_packet <= 1'b1;
            result.frame_error    <= 1'b0 | 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---- checks ----
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_error |->
      result.element_value == '0 && result.last_of_packet && result.element_index == '0)
    else $error("error item carries data");

  a_bad_term: assert property (@(posedge clk) disable iff (rst)
    rx_fire && in_sync && !is_data && rx.rx_byte != NEWLINE |=>
      state == S_ERR && !in_sync)
    else $error("bad terminator did not drop sync");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.frame_error |-> result.element_index < elems_r)
    else $error("element index beyond packet");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_CONV && !out_free |=> state == S_CONV)
    else $error("converter result left before output was free");

endmodule
`default_nettype wire

### bench/deframer_result_check.sv
`timescale 1ns / 1ps
module deframer_result_check
  import nfod_pkg::*;
#(
  parameter int MAX_ELEMENTS = 9
) (
  input  logic   clk,
  input  logic   rst,
  nfod_byte_if   rx,
  nfod_result_if result,
  input  logic   cfg_we,
  input  logic   cfg_index,
  input  fmt_t   cfg_data,
  output int     mismatches,
  output int     outstanding
);

  localparam int MEM_BYTES = MAX_ELEMENTS * 4;

  typedef struct packed {
    value_t value;
    index_t index;
    logic   last;
    logic   err;
  } element_t;

  logic     count_mode;
  fmt_t     fmt;
  logic     synced;
  int       position;
  byte_t    packet_mem [MEM_BYTES];
  element_t pending_elements [$];
  element_t got;
  element_t want;

  function automatic value_t q831_from_float(input logic [31:0] w);
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [63:0] mag;
    int          sh;
    value_t      v;
    ex   = w[30:23];
    frac = w[22:0];
    sh   = int'(ex) - int'(EXP_UNITY);
    if (ex == 8'hFF) begin
      // NaN reads as zero, infinities saturate
      v = (frac != '0) ? '0 : (w[31] ? SAT_NEG : SAT_POS);
    end else if (ex == 8'h00) begin
      v = '0;
    end else if (ex >= EXP_SAT) begin
      v = w[31] ? SAT_NEG : SAT_POS;
    end else begin
      if (sh >= 0)
        mag = {40'b0, 1'b1, frac} << sh;
      else if (-sh >= 32)
        mag = '0;
      else
        mag = {40'b0, 1'b1, frac} >> (-sh);
      v = mag[39:0];
      if (w[31])
        v = -v;
    end
    return v;
  endfunction

  function automatic value_t element_from_bytes(input int idx);
    logic [31:0] w;
    int          base;
    if (fmt == FMT_Q15) begin
      base = idx * 2;
      w = {16'h0, packet_mem[base + 1], packet_mem[base]};
      return {{8{w[15]}}, w[15:0], 16'h0};
    end
    base = idx * 4;
    w = {packet_mem[base + 3], packet_mem[base + 2], packet_mem[base + 1], packet_mem[base]};
    case (fmt)
      FMT_FLOAT: return q831_from_float(w);
      FMT_Q29:   return {{6{w[31]}}, w, 2'b00};
      default:   return {{8{w[31]}}, w};
    endcase
  endfunction

  task automatic take_byte(input byte_t b);
    int       elems;
    int       psize;
    element_t e;
    elems = count_mode ? MAX_ELEMENTS : int'(ANGLE_ELEMENTS);
    psize = elems * ((fmt == FMT_Q15) ? 2 : 4);
    if (!synced) begin
      if (b == NEWLINE) begin
        synced   = 1'b1;
        position = 0;
      end
    end else if (position < psize) begin
      packet_mem[position % MEM_BYTES] = b;
      position++;
    end else begin
      // byte at or past the current length is the terminator
      position = 0;
      if (b != NEWLINE) begin
        synced = 1'b0;
        e = '{value: '0, index: '0, last: 1'b1, err: 1'b1};
        pending_elements.push_back(e);
      end else begin
        for (int i = 0; i < elems; i++) begin
          e.value = element_from_bytes(i);
          e.index = 4'(i);
          e.last  = (i == elems - 1);
          e.err   = 1'b0;
          pending_elements.push_back(e);
        end
      end
    end
  endtask

  task automatic report_bad(input string what, input element_t w, input element_t g);
    mismatches++;
    if (mismatches <= 10)
      $display({"%m: %s at %0t: expected value %0d index %0d last %0b error %0b,",
                " got value %0d index %0d last %0b error %0b"},
               what, $time, $signed(w.value), w.index, w.last, w.err,
               $signed(g.value), g.index, g.last, g.err);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      count_mode = 1'b0;
      fmt        = FMT_FLOAT;
      synced     = 1'b0;
      position   = 0;
      pending_elements.delete();
    end else begin
      if (result.valid && result.ready) begin
        got = {result.element_value, result.element_index, result.last_of_packet,
               result.frame_error};
        if (pending_elements.size() == 0) begin
          report_bad("result with nothing expected", '0, got);
        end else begin
          want = pending_elements.pop_front();
          if (got.value !== want.value || got.index !== want.index ||
              got.last !== want.last || got.err !== want.err)
            report_bad("result mismatch", want, got);
        end
      end
      // a byte taken at this edge still sees the old register values
      if (rx.valid && rx.ready)
        take_byte(rx.rx_byte);
      if (cfg_we) begin
        if (cfg_index == REG_ELEMENT_COUNT_MODE)
          count_mode = cfg_data[0];
        else
          fmt = cfg_data;
      end
    end
    outstanding <= pending_elements.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  import nfod_pkg::*;

  localparam int ITEM_TARGET   = 460;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_ELEMENTS  = 9;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  fmt_t cfg_data;

  int   mismatches;
  int   outstanding;
  int   cycle_count = 0;
  int   sent_items = 0;
  logic cur_mode = 1'b0;
  fmt_t cur_fmt = FMT_FLOAT;
  bit   synced = 1'b0;
  bit   steady = 1'b0;
  logic [31:0] word_q [$];

  nfod_byte_if   rx_if ();
  nfod_result_if res_if ();

  newline_framed_orientation_deframer_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx_if),
    .result   (res_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  deframer_result_check #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_results (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx_if),
    .result     (res_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 70)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    if (r < 98)
      return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_stall
    int stall;
    stall = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
        stall = pick_gap();
      end
    end
  end

  function automatic byte_t any_but_newline();
    byte_t b;
    do b = 8'($urandom); while (b == NEWLINE);
    return b;
  endfunction

  function automatic logic [31:0] random_word(input fmt_t f);
    logic [31:0] w;
    w = $urandom;
    if (f != FMT_FLOAT) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 3))
          0:       w = (f == FMT_Q15) ? 32'h0000_8000 : 32'h8000_0000;
          1:       w = (f == FMT_Q15) ? 32'h0000_7FFF : 32'h7FFF_FFFF;
          2:       w = '0;
          default: w = '1;
        endcase
      end
      return w;
    end
    // bias exponents toward the window that maps into Q8.31
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: w[30:23] = 8'($urandom_range(100, 140));
      5:             w[30:23] = 8'($urandom_range(84, 99));
      6:             w[30:23] = 8'hFF;
      7:             begin w[30:23] = 8'hFF; w[22:0] = '0; end
      8:             w[30:23] = 8'h00;
      default:       ;
    endcase
    return w;
  endfunction

  task automatic put_byte(input byte_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    sent_items++;
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // writes both registers; the mode register's unused upper data bit is random
  task automatic configure(input logic mode, input fmt_t f);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ELEMENT_COUNT_MODE;
    cfg_data  <= {($urandom_range(0, 1) == 1), mode};
    @(posedge clk);
    cfg_index <= REG_NUMBER_FORMAT;
    cfg_data  <= f;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = mode;
    cur_fmt  = f;
  endtask

  // sends word_q as one packet, padded with random elements
  task automatic send_words(input byte_t term);
    int elems;
    int esize;
    elems = cur_mode ? MAX_ELEMENTS : int'(ANGLE_ELEMENTS);
    esize = (cur_fmt == FMT_Q15) ? 2 : 4;
    while (word_q.size() < elems)
      word_q.push_back(random_word(cur_fmt));
    for (int i = 0; i < elems; i++)
      for (int k = 0; k < esize; k++)
        put_byte(word_q[i][8 * k +: 8]);
    put_byte(term);
    if (term != NEWLINE)
      synced = 1'b0;
    word_q.delete();
  endtask

  task automatic resync();
    repeat ($urandom_range(0, 3)) put_byte(any_but_newline());
    put_byte(NEWLINE);
    synced = 1'b1;
  endtask

  // random bytes, then enough non-newlines to force loss of sync from any position
  task automatic scramble();
    synced = 1'b0;
    repeat ($urandom_range(3, 15)) put_byte(8'($urandom));
    repeat (MAX_ELEMENTS * 4 + 1) put_byte(any_but_newline());
  endtask

  initial begin : stimulus
    int packets;
    int r;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_ELEMENT_COUNT_MODE;
    cfg_data      <= FMT_FLOAT;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: three floats; bytes before the first newline are dropped
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(NEWLINE);
    synced = 1'b1;
    word_q = '{32'h4380_0000, 32'hC380_0000, 32'h7FC0_0000};
    send_words(NEWLINE);
    word_q = '{32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001};
    send_words(NEWLINE);
    // bad terminator
    word_q = '{32'h437F_FFFF, 32'hB000_0000, 32'h2F80_0000};
    send_words(8'hFF);
    resync();

    settle();
    configure(1'b1, FMT_Q15);
    word_q = '{32'h8000, 32'h7FFF, 32'h0000, 32'hFFFF, 32'h0001};
    send_words(NEWLINE);
    settle();
    configure(1'b1, FMT_Q31);
    word_q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF};
    send_words(NEWLINE);
    settle();
    configure(1'b0, FMT_Q29);
    word_q = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0A0A_0A0A};
    send_words(NEWLINE);

    // length shrinks mid-packet: next byte is taken as the terminator
    settle();
    configure(1'b1, FMT_FLOAT);
    repeat (20) put_byte(8'($urandom));
    settle();
    configure(1'b0, FMT_FLOAT);
    put_byte(NEWLINE);
    // length grows mid-packet
    settle();
    configure(1'b0, FMT_Q15);
    repeat (4) put_byte(8'($urandom));
    settle();
    configure(1'b1, FMT_Q31);
    repeat (32) put_byte(8'($urandom));
    put_byte(NEWLINE);

    while (sent_items < ITEM_TARGET) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      configure($urandom_range(0, 1) == 1, fmt_t'($urandom_range(0, 3)));
      if (!synced)
        resync();
      packets = $urandom_range(2, 6);
      repeat (packets) begin
        r = $urandom_range(0, 99);
        if (r < 80) begin
          send_words(NEWLINE);
        end else if (r < 92) begin
          send_words(any_but_newline());
          resync();
        end else begin
          scramble();
          resync();
        end
      end
    end

    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
